FILE: design/bmt_pkg.sv
`default_nettype none

package bmt_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned USED_W  = 4;

  // default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [HASH_W-1:0] mod_hash;
    logic [POS_W-1:0]  code_position;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic              error;
    logic [USED_W-1:0] entries_used;
  } out_item_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic capture;
    logic append;
    logic start_token;
    logic shift_step;
    logic shift_last;
  } bmt_ctl_t;

  // where a cell sits relative to the entry count
  typedef struct packed {
    logic occupied;
    logic tail;
    logic last;
  } bmt_place_t;

endpackage

`default_nettype wire

FILE: design/breakpoint_match_table.sv
`default_nettype none
// channel  | ports                          | direction | payload
// ---------+--------------------------------+-----------+------------------------
// input    | in_valid, in_ready, in_data    | in        | operation, hash, position
// result   | out_valid, out_ready, out_data | out       | hit, error, entries_used
//
// check and set: the compare is captured in every cell at the input transfer, then
// the sequencer decides, then the result register is loaded; no new input is
// taken in between. a clear that hits also walks the removal token through the
// cell chain, from the matching entry up to the last stored one, before the
// result is loaded. reset empties the table by zeroing the count; no clearing
// pass.
// a new item is taken once the previous result is in the output register; a
// stalled result holds there and blocks the next result load and further input.

module breakpoint_match_table #(
  parameter int unsigned TABLE_DEPTH = bmt_pkg::TABLE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bmt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bmt_pkg::out_item_t  out_data
);
  import bmt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  in_item_t         item_r;
  logic             hit_r, hit_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic             out_load;

  bmt_ctl_t         ctl;
  bmt_place_t       place   [TABLE_DEPTH];
  logic [HASH_W-1:0] hash_w [TABLE_DEPTH];
  logic [POS_W-1:0]  pos_w  [TABLE_DEPTH];
  logic [HASH_W-1:0] nb_hash_w [TABLE_DEPTH];
  logic [POS_W-1:0]  nb_pos_w  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_w;
  logic [TABLE_DEPTH-1:0] token_w;
  logic [TABLE_DEPTH-1:0] token_in_w;
  logic [TABLE_DEPTH-1:0] last_w;

  logic             in_xfer;
  logic             hit_any;
  logic             full;
  logic             token_done;
  logic [31:0]      count_ext;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign place[i].occupied = (count_r > CNT_W'(i));
    assign place[i].tail     = (count_r == CNT_W'(i));
    assign place[i].last     = (count_r == CNT_W'(i + 1));
    assign last_w[i]         = place[i].last;

    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nb_hash_w[i] = hash_w[i];
      assign nb_pos_w[i]  = pos_w[i];
    end else begin : g_mid
      assign nb_hash_w[i] = hash_w[i+1];
      assign nb_pos_w[i]  = pos_w[i+1];
    end

    if (i == 0) begin : g_first
      assign token_in_w[i] = 1'b0;
    end else begin : g_next
      assign token_in_w[i] = token_w[i-1];
    end

    bmt_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .place         (place[i]),
      .key_hash      (in_data.mod_hash),
      .key_position  (in_data.code_position),
      .item_hash     (item_r.mod_hash),
      .item_position (item_r.code_position),
      .nb_hash       (nb_hash_w[i]),
      .nb_position   (nb_pos_w[i]),
      .token_in      (token_in_w[i]),
      .hash_q        (hash_w[i]),
      .position_q    (pos_w[i]),
      .match_q       (match_w[i]),
      .token_q       (token_w[i])
    );
  end

  assign hit_any    = |match_w;
  assign full       = (count_r == CNT_W'(TABLE_DEPTH));
  assign token_done = |(token_w & last_w);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    hit_nxt         = hit_r;
    err_nxt         = err_r;
    ctl             = '0;
    ctl.capture     = in_xfer;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        hit_nxt   = hit_any;
        err_nxt   = 1'b0;
        state_nxt = S_DONE;
        case (item_r.operation)
          OP_SET: begin
            if (!hit_any) begin
              if (full) begin
                err_nxt = 1'b1;
              end else begin
                ctl.append = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end
            end
          end
          OP_CLEAR: begin
            if (hit_any) begin
              ctl.start_token = 1'b1;
              state_nxt       = S_SHIFT;
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        ctl.shift_step = 1'b1;
        ctl.shift_last = token_done;
        if (token_done) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign count_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    err_r <= err_nxt;
    if (in_xfer) item_r <= in_data;
    if (out_load) begin
      out_data_r.hit          <= hit_r;
      out_data_r.error        <= err_r;
      out_data_r.entries_used <= count_ext[USED_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> $onehot(token_w))
    else $error("removal token lost or duplicated");

  a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (token_w == '0))
    else $error("token left in chain after a clear");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_err_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.error && out_data_r.hit))
    else $error("error reported together with hit");

  a_shift_was_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DECIDE) && (state_nxt == S_SHIFT)) |-> (count_r != '0))
    else $error("removal started on an empty table");

endmodule

`default_nettype wire

FILE: design/bmt_cell.sv
`default_nettype none

module bmt_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  bmt_pkg::bmt_ctl_t          ctl,
  input  bmt_pkg::bmt_place_t        place,
  input  wire [bmt_pkg::HASH_W-1:0]  key_hash,
  input  wire [bmt_pkg::POS_W-1:0]   key_position,
  input  wire [bmt_pkg::HASH_W-1:0]  item_hash,
  input  wire [bmt_pkg::POS_W-1:0]   item_position,
  input  wire [bmt_pkg::HASH_W-1:0]  nb_hash,
  input  wire [bmt_pkg::POS_W-1:0]   nb_position,
  input  wire                        token_in,
  output logic [bmt_pkg::HASH_W-1:0] hash_q,
  output logic [bmt_pkg::POS_W-1:0]  position_q,
  output logic                       match_q,
  output logic                       token_q
);
  import bmt_pkg::*;

  logic [HASH_W-1:0] hash_r;
  logic [POS_W-1:0]  position_r;
  logic              match_r;
  logic              match_nxt;
  logic              token_r;
  logic              token_nxt;

  // local compare against the incoming key
  always_comb begin
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = place.occupied && (hash_r == key_hash) && (position_r == key_position);
    end
  end

  // removal token walks one cell per cycle toward the tail
  always_comb begin
    token_nxt = token_r;
    if (ctl.start_token) begin
      token_nxt = match_r;
    end else if (ctl.shift_step) begin
      token_nxt = ctl.shift_last ? 1'b0 : token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      token_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
      token_r <= token_nxt;
    end
  end

  // entry storage: append at the tail, pull from the neighbor under the token
  always_ff @(posedge clk) begin
    if (ctl.append && place.tail) begin
      hash_r     <= item_hash;
      position_r <= item_position;
    end else if (ctl.shift_step && token_r) begin
      hash_r     <= nb_hash;
      position_r <= nb_position;
    end
  end

  assign hash_q     = hash_r;
  assign position_q = position_r;
  assign match_q    = match_r;
  assign token_q    = token_r;

endmodule

`default_nettype wire
